// ===== rtl/core/kwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types, codes and helpers of the k-way merge heap core.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned SRC_W    = 8;
  localparam int unsigned KEY_HI_W = 16;
  localparam int unsigned KEY_LO_W = 64;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned PRIME_W  = 9;
  localparam int unsigned SRC_MAX  = 256;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_WRONG  = 2'd2
  } kwm_kind_e;

  typedef struct packed {
    logic [SRC_W-1:0]    source;
    logic                has_record;
    logic [KEY_HI_W-1:0] key_high;
    logic [KEY_LO_W-1:0] key_low;
    logic [TAG_W-1:0]    tag;
  } kwm_in_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [SRC_W-1:0]    out_source;
    logic [KEY_HI_W-1:0] out_key_high;
    logic [KEY_LO_W-1:0] out_key_low;
    logic [TAG_W-1:0]    out_tag;
  } kwm_out_t;

  typedef struct packed {
    logic [KEY_HI_W-1:0] key_high;
    logic [KEY_LO_W-1:0] key_low;
    logic [TAG_W-1:0]    tag;
    logic [SRC_W-1:0]    source;
  } kwm_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POST,
    ST_POP,
    ST_POP_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_EMIT
  } kwm_state_e;

  typedef enum logic [2:0] {
    HOLE_KEEP,
    HOLE_COUNT,
    HOLE_PARENT,
    HOLE_CHILD,
    HOLE_ZERO
  } kwm_hole_e;

  typedef enum logic [1:0] {
    WR_CARRY,
    WR_PARENT,
    WR_CHILD
  } kwm_wsel_e;

  typedef enum logic [1:0] {
    RD_PARENT,
    RD_POP,
    RD_CHILD
  } kwm_rsel_e;

  typedef struct packed {
    logic      cap_item;
    logic      res_wrong;
    logic      res_done;
    logic      res_root;
    kwm_hole_e hole_op;
    logic      wr_en;
    kwm_wsel_e wr_sel;
    kwm_rsel_e rd_sel;
    logic      count_dec;
    logic      prime_step;
    logic      merge_reset;
    logic      load_out;
  } kwm_cmd_t;

  typedef struct packed {
    logic src_ok;
    logic has_record;
    logic heap_full;
    logic hole_zero;
    logic priming;
    logic prime_done;
    logic heap_empty;
    logic no_left;
    logic up_first;
    logic dn_first;
    logic out_free;
  } kwm_status_t;

  // Smaller key leaves first; equal keys leave in source order.
  function automatic logic goes_first(input kwm_entry_t a, input kwm_entry_t b);
    goes_first = {a.key_high, a.key_low, a.source} < {b.key_high, b.key_low, b.source};
  endfunction

endpackage

// ===== rtl/core/kwm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer of the merge core: source check, sift-up insert, pop and sift-down.
// ----------------------------------------------------------------------------
module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  kwm_status_t status_i,
  output kwm_cmd_t    cmd_o
);

  kwm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.src_ok) begin
          state_d = ST_EMIT;
        end else if (status_i.has_record && !status_i.heap_full) begin
          state_d = ST_UP_RD;
        end else begin
          state_d = ST_POST;
        end
      end
      ST_UP_RD: begin
        state_d = status_i.hole_zero ? ST_POST : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_d = status_i.up_first ? ST_UP_RD : ST_POST;
      end
      ST_POST: begin
        if (status_i.priming && !status_i.prime_done) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        state_d = status_i.heap_empty ? ST_EMIT : ST_POP_LD;
      end
      ST_POP_LD: begin
        state_d = status_i.heap_empty ? ST_EMIT : ST_DN_RD;
      end
      ST_DN_RD: begin
        state_d = status_i.no_left ? ST_EMIT : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_d = status_i.dn_first ? ST_DN_RD : ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.hole_op     = HOLE_KEEP;
    cmd_o.wr_sel      = WR_CARRY;
    cmd_o.rd_sel      = RD_PARENT;
    in_stall_o        = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.cap_item = in_valid_i;
      end
      ST_CHECK: begin
        if (!status_i.src_ok) begin
          cmd_o.res_wrong = 1'b1;
        end else if (status_i.has_record && !status_i.heap_full) begin
          cmd_o.hole_op = HOLE_COUNT;
        end
      end
      ST_UP_RD: begin
        if (status_i.hole_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_CARRY;
        end else begin
          cmd_o.rd_sel = RD_PARENT;
        end
      end
      ST_UP_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.up_first) begin
          cmd_o.wr_sel  = WR_PARENT;
          cmd_o.hole_op = HOLE_PARENT;
        end else begin
          cmd_o.wr_sel = WR_CARRY;
        end
      end
      ST_POST: begin
        cmd_o.prime_step = status_i.priming;
      end
      ST_POP: begin
        if (status_i.heap_empty) begin
          cmd_o.res_done    = 1'b1;
          cmd_o.merge_reset = 1'b1;
        end else begin
          cmd_o.rd_sel    = RD_POP;
          cmd_o.count_dec = 1'b1;
        end
      end
      ST_POP_LD: begin
        cmd_o.res_root = 1'b1;
        cmd_o.hole_op  = HOLE_ZERO;
      end
      ST_DN_RD: begin
        if (status_i.no_left) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_CARRY;
        end else begin
          cmd_o.rd_sel = RD_CHILD;
        end
      end
      ST_DN_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.dn_first) begin
          cmd_o.wr_sel  = WR_CHILD;
          cmd_o.hole_op = HOLE_CHILD;
        end else begin
          cmd_o.wr_sel = WR_CARRY;
        end
      end
      ST_EMIT: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/kwm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_dp
// Heap memory, merge bookkeeping registers, comparators and output register.
// ----------------------------------------------------------------------------
module kwm_dp
  import kwm_pkg::*;
#(
  parameter int unsigned SOURCES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kwm_in_t          in_item_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output kwm_out_t         out_item_o,
  input  kwm_cmd_t         cmd_i,
  output kwm_status_t      status_o
);

  localparam int unsigned AW    = $clog2(SOURCES);
  localparam int unsigned CW    = $clog2(SOURCES + 1);
  localparam int unsigned LW    = AW + 1;
  localparam int unsigned BOUND = (SOURCES < SRC_MAX) ? SOURCES : SRC_MAX;

  kwm_entry_t heap_mem [SOURCES];
  kwm_entry_t rd_a_q, rd_b_q;
  kwm_entry_t carry_q, wr_data;
  kwm_in_t    item_q;
  kwm_out_t   res_q, out_q;
  logic       out_valid_q;

  logic [CW-1:0]      count_q;
  logic [AW-1:0]      hole_q;
  logic [LW-1:0]      child_l_q;
  logic               r_valid_q;
  logic [PRIME_W-1:0] primed_q;
  logic [SRC_W-1:0]   exp_q;
  logic               merging_q;
  logic [CFG_W-1:0]   cfg_q;

  logic [AW-1:0]      parent_idx;
  logic [LW-1:0]      left_idx, right_idx;
  logic [CW-1:0]      count_m1;
  logic [AW-1:0]      rd_a_addr, rd_b_addr;
  logic [AW-1:0]      child_idx;
  logic               choose_r;
  logic [PRIME_W-1:0] primed_next;
  logic [CFG_W-1:0]   active;
  logic               out_free;

  assign parent_idx  = (hole_q - 1'b1) >> 1;
  assign left_idx    = {hole_q, 1'b1};
  assign right_idx   = left_idx + 1'b1;
  assign count_m1    = count_q - 1'b1;
  assign primed_next = primed_q + 1'b1;
  assign choose_r    = r_valid_q && goes_first(rd_b_q, rd_a_q);
  assign child_idx   = choose_r ? AW'(child_l_q + 1'b1) : child_l_q[AW-1:0];
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cfg_q == '0) begin
      active = CFG_W'(1);
    end else if (cfg_q > CFG_W'(BOUND)) begin
      active = CFG_W'(BOUND);
    end else begin
      active = cfg_q;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_POP: begin
        rd_a_addr = '0;
        rd_b_addr = count_m1[AW-1:0];
      end
      RD_CHILD: begin
        rd_a_addr = left_idx[AW-1:0];
        rd_b_addr = right_idx[AW-1:0];
      end
      default: begin
        rd_a_addr = parent_idx;
        rd_b_addr = parent_idx;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_PARENT: wr_data = rd_a_q;
      WR_CHILD:  wr_data = choose_r ? rd_b_q : rd_a_q;
      default:   wr_data = carry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) heap_mem[hole_q] <= wr_data;
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      item_q  <= in_item_i;
      carry_q <= '{key_high: in_item_i.key_high, key_low: in_item_i.key_low,
                   tag: in_item_i.tag, source: in_item_i.source};
    end else if (cmd_i.res_root) begin
      carry_q <= rd_b_q;
    end
    case (cmd_i.hole_op)
      HOLE_COUNT:  hole_q <= count_q[AW-1:0];
      HOLE_PARENT: hole_q <= parent_idx;
      HOLE_CHILD:  hole_q <= child_idx;
      HOLE_ZERO:   hole_q <= '0;
      default:     hole_q <= hole_q;
    endcase
    if (cmd_i.rd_sel == RD_CHILD) begin
      child_l_q <= left_idx;
      r_valid_q <= right_idx < LW'(count_q);
    end
    if (cmd_i.res_wrong) begin
      res_q <= '{result_kind: KIND_WRONG, out_source: exp_q, default: '0};
    end else if (cmd_i.res_done) begin
      res_q <= '{result_kind: KIND_DONE, default: '0};
    end else if (cmd_i.res_root) begin
      res_q <= '{result_kind: KIND_RECORD, out_source: rd_a_q.source,
                 out_key_high: rd_a_q.key_high, out_key_low: rd_a_q.key_low,
                 out_tag: rd_a_q.tag};
    end
    if (cmd_i.load_out) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      primed_q    <= '0;
      exp_q       <= '0;
      merging_q   <= 1'b0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (cmd_i.hole_op == HOLE_COUNT) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.count_dec) begin
        count_q <= count_m1;
      end
      if (cmd_i.prime_step) begin
        primed_q <= primed_next;
        exp_q    <= primed_next[SRC_W-1:0];
      end else if (cmd_i.merge_reset) begin
        primed_q  <= '0;
        exp_q     <= '0;
        merging_q <= 1'b0;
      end else if (cmd_i.res_root) begin
        exp_q     <= rd_a_q.source;
        merging_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.src_ok     = item_q.source == exp_q;
  assign status_o.has_record = item_q.has_record;
  assign status_o.heap_full  = count_q >= CW'(SOURCES);
  assign status_o.hole_zero  = hole_q == '0;
  assign status_o.priming    = !merging_q;
  assign status_o.prime_done = primed_next >= active;
  assign status_o.heap_empty = count_q == '0;
  assign status_o.no_left    = left_idx >= LW'(count_q);
  assign status_o.up_first   = goes_first(carry_q, rd_a_q);
  assign status_o.dn_first   = choose_r ? goes_first(rd_b_q, carry_q)
                                        : goes_first(rd_a_q, carry_q);
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/k_way_merge_min_heap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_min_heap_core
// K-way merge of sorted record streams through a binary min-heap.
// ----------------------------------------------------------------------------
// The core holds one head record per source in a heap memory of SOURCES entries
// with one write port and two registered read ports. During priming the sources
// offer their first item in order 0, 1, 2 and so on; after that each item from
// the named source is inserted and the smallest record is popped and emitted,
// together with the source that must supply the next item, or a done result is
// emitted once the heap is empty. An item that yields a record passes the idle,
// check, post, pop, load and emit states, plus the sift-up of the new record and
// the sift-down after the pop. Each walk reads and then compares once per level
// that a record moves, and a walk that is not needed is skipped. A priming item
// without result goes back to idle after post. An item from the wrong source is
// answered from the check state and leaves the heap untouched. The input channel
// takes the next item while a result is still waiting in the output register.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap_core
  import kwm_pkg::*;
#(
  parameter int unsigned SOURCES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kwm_in_t          in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output kwm_out_t         out_item_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  kwm_cmd_t    cmd;
  kwm_status_t status;

  kwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kwm_dp #(
    .SOURCES (SOURCES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== verif/kwm_merge_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_merge_sb_pkg
// Scoreboard for the k-way merge heap core. It keeps its own heap of head
// records and its own priming and merging state, so it can predict what each
// accepted item produces. It then checks every result field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
package kwm_merge_sb_pkg;

  import kwm_pkg::*;

  class merge_scoreboard;

    kwm_entry_t       heap [SRC_MAX];
    int unsigned      fill;
    int unsigned      primed;
    logic [SRC_W-1:0] next_source;
    bit               merging;
    bit               merge_over;
    logic [CFG_W-1:0] n_sources;
    kwm_out_t         pending_results [$];
    int unsigned      items_in;
    int unsigned      records_out;
    int unsigned      merges_done;
    int unsigned      wrong_items;
    int unsigned      results_seen;
    int unsigned      errors;

    function new();
      fill         = 0;
      primed       = 0;
      next_source  = '0;
      merging      = 1'b0;
      merge_over   = 1'b0;
      n_sources    = CFG_RESET;
      items_in     = 0;
      records_out  = 0;
      merges_done  = 0;
      wrong_items  = 0;
      results_seen = 0;
      errors       = 0;
    endfunction

    function void set_sources(input logic [CFG_W-1:0] value);
      n_sources = value;
    endfunction

    function void queue_result(input kwm_out_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function int unsigned active_sources();
      int unsigned n;
      n = n_sources;
      if (n == 0) n = 1;
      if (n > SRC_MAX) n = SRC_MAX;
      return n;
    endfunction

    function bit precedes(input kwm_entry_t a, input kwm_entry_t b);
      if (a.key_high != b.key_high) return a.key_high < b.key_high;
      if (a.key_low != b.key_low) return a.key_low < b.key_low;
      return a.source < b.source;
    endfunction

    function void heap_push(input kwm_entry_t e);
      int unsigned i;
      int unsigned p;
      kwm_entry_t  t;
      if (fill >= SRC_MAX) return;
      i = fill;
      heap[i] = e;
      fill++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!precedes(heap[i], heap[p])) break;
        t = heap[i];
        heap[i] = heap[p];
        heap[p] = t;
        i = p;
      end
    endfunction

    function kwm_out_t pop_min();
      kwm_out_t    r;
      kwm_entry_t  t;
      int unsigned i;
      int unsigned l;
      int unsigned m;
      r = '0;
      if (fill == 0) begin
        r.result_kind = KIND_DONE;
        primed      = 0;
        next_source = '0;
        merging     = 1'b0;
        merge_over  = 1'b1;
        merges_done++;
        return r;
      end
      r.result_kind  = KIND_RECORD;
      r.out_source   = heap[0].source;
      r.out_key_high = heap[0].key_high;
      r.out_key_low  = heap[0].key_low;
      r.out_tag      = heap[0].tag;
      next_source = heap[0].source;
      merging     = 1'b1;
      records_out++;
      fill--;
      if (fill > 0) heap[0] = heap[fill];
      i = 0;
      forever begin
        l = 2 * i + 1;
        m = i;
        if (l < fill && precedes(heap[l], heap[m])) m = l;
        if (l + 1 < fill && precedes(heap[l + 1], heap[m])) m = l + 1;
        if (m == i) break;
        t = heap[i];
        heap[i] = heap[m];
        heap[m] = t;
        i = m;
      end
      return r;
    endfunction

    function void note_input(input kwm_in_t it);
      kwm_out_t   r;
      kwm_entry_t e;
      items_in++;
      if (it.source != next_source) begin
        r = '0;
        r.result_kind = KIND_WRONG;
        r.out_source  = next_source;
        queue_result(r);
        wrong_items++;
        return;
      end
      if (it.has_record) begin
        e.key_high = it.key_high;
        e.key_low  = it.key_low;
        e.tag      = it.tag;
        e.source   = it.source;
        heap_push(e);
      end
      if (!merging) begin
        primed++;
        next_source = primed[SRC_W-1:0];
        if (primed < active_sources()) return;
      end
      queue_result(pop_min());
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", msg);
    endtask

    task check_result(input kwm_out_t got);
      kwm_out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d source %0d", got.result_kind,
                         got.out_source));
        return;
      end
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("result %0d kind %0d, want %0d", results_seen, got.result_kind,
                         want.result_kind));
      if (got.out_source !== want.out_source)
        report($sformatf("result %0d source %0d, want %0d", results_seen, got.out_source,
                         want.out_source));
      if (got.out_key_high !== want.out_key_high)
        report($sformatf("result %0d key_high %h, want %h", results_seen,
                         got.out_key_high, want.out_key_high));
      if (got.out_key_low !== want.out_key_low)
        report($sformatf("result %0d key_low %h, want %h", results_seen, got.out_key_low,
                         want.out_key_low));
      if (got.out_tag !== want.out_tag)
        report($sformatf("result %0d tag %h, want %h", results_seen, got.out_tag,
                         want.out_tag));
    endtask

  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the k-way merge heap core.
// A short directed sequence covers extreme keys, ties between sources, wrong
// source items and merges that end in priming. Random merges of sorted streams
// then run under several source counts, with random idling on both channels
// and one long output hold-off. A scoreboard predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_top;

  import kwm_pkg::*;
  import kwm_merge_sb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned SETTLE      = 64;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  kwm_in_t          in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  kwm_out_t         out_item;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;

  merge_scoreboard  sb = new();
  int unsigned      cycle_count = 0;
  int unsigned      settings_used = 0;
  int unsigned      remaining [SRC_MAX];
  logic [79:0]      last_key [SRC_MAX];

  k_way_merge_min_heap_core #(
    .SOURCES(SRC_MAX)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit calm();
    return sb.items_in >= 1000 && sb.items_in < 1300;
  endfunction

  function automatic kwm_in_t mk_item(input logic [SRC_W-1:0] src, input logic has,
                                      input logic [KEY_HI_W-1:0] kh,
                                      input logic [KEY_LO_W-1:0] kl,
                                      input logic [TAG_W-1:0] tag);
    kwm_in_t it;
    it.source     = src;
    it.has_record = has;
    it.key_high   = kh;
    it.key_low    = kl;
    it.tag        = tag;
    return it;
  endfunction

  function automatic logic [79:0] first_key();
    logic [79:0] k;
    case ($urandom_range(0, 3))
      0: k = '0;
      1: k = 80'($urandom_range(0, 7));
      2: k = {16'($urandom), $urandom, $urandom};
      default: k = ~80'd0 - 80'($urandom_range(0, 3));
    endcase
    return k;
  endfunction

  function automatic logic [79:0] bump_key(input logic [79:0] k);
    logic [79:0] d;
    if ($urandom_range(0, 9) == 0) d = 80'($urandom);
    else d = 80'($urandom_range(0, 3));
    if (k > ~80'd0 - d) return ~80'd0;
    return k + d;
  endfunction

  function automatic void start_merge(input int unsigned n, input int unsigned max_len);
    for (int s = 0; s < SRC_MAX; s++) begin
      remaining[s] = (s < n) ? $urandom_range(0, max_len) : 0;
      last_key[s]  = first_key();
    end
  endfunction

  function automatic kwm_in_t next_item();
    kwm_in_t          it;
    logic [SRC_W-1:0] s;
    s = sb.next_source;
    it.tag      = $urandom;
    it.key_high = 16'($urandom);
    it.key_low  = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 6) begin
      it.source     = s + 8'($urandom_range(1, 255));
      it.has_record = 1'($urandom_range(0, 1));
      return it;
    end
    it.source = s;
    if (remaining[s] > 0) begin
      remaining[s]--;
      last_key[s]   = bump_key(last_key[s]);
      it.has_record = 1'b1;
      {it.key_high, it.key_low} = last_key[s];
    end else begin
      it.has_record = 1'b0;
    end
    return it;
  endfunction

  task automatic send_item(input kwm_in_t it);
    while (!calm() && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sources(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    sb.set_sources(value);
    settings_used++;
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] value, input int unsigned merges,
                           input int unsigned max_len);
    write_sources(value);
    repeat (merges) begin
      start_merge(sb.active_sources(), max_len);
      sb.merge_over = 1'b0;
      while (!sb.merge_over) send_item(next_item());
    end
  endtask

  initial begin : receiver
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm() && ($urandom_range(0, 99) < 29);
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_item);
        if (!held && sb.results_seen == 200) begin
          held      = 1'b1;
          hold_left = 500;
        end
      end
    end
  end

  initial begin : stimulus
    logic [KEY_LO_W-1:0] tie_lo;
    tie_lo = 64'h0123_4567_89ab_cdef;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_sources(9'd0);
    send_item(mk_item(8'd0, 1'b1, '1, '1, '1));
    send_item(mk_item(8'd255, 1'b0, '0, '0, '0));
    send_item(mk_item(8'd0, 1'b1, '0, '0, '0));
    send_item(mk_item(8'd0, 1'b0, '1, '1, '1));
    send_item(mk_item(8'd0, 1'b0, '0, '0, '0));

    write_sources(9'd3);
    send_item(mk_item(8'd0, 1'b1, 16'h00ff, tie_lo, 32'h1111_0000));
    send_item(mk_item(8'd2, 1'b1, 16'h00ff, tie_lo, 32'h2222_0000));
    send_item(mk_item(8'd1, 1'b1, 16'h00ff, tie_lo, 32'h3333_0000));
    send_item(mk_item(8'd2, 1'b1, 16'h00ff, tie_lo, 32'h4444_0000));
    send_item(mk_item(8'd0, 1'b0, '0, '0, '0));
    send_item(mk_item(8'd1, 1'b0, '0, '0, '0));
    send_item(mk_item(8'd2, 1'b0, '0, '0, '0));

    write_sources(9'd2);
    send_item(mk_item(8'd0, 1'b1, 16'h0001, '0, 32'hdead_beef));
    send_item(mk_item(8'd1, 1'b1, 16'h0000, '1, 32'hcafe_f00d));
    send_item(mk_item(8'd1, 1'b0, '0, '0, '0));
    send_item(mk_item(8'd0, 1'b0, '0, '0, '0));

    run_phase(9'd256, 1, 1);
    run_phase(9'd511, 1, 1);
    run_phase(9'd1, 20, 6);
    run_phase(9'd0, 10, 4);
    run_phase(9'd2, 10, 6);
    run_phase(9'd3, 8, 6);
    run_phase(9'd16, 3, 5);
    while (sb.items_in < ITEM_TARGET) run_phase(9'($urandom_range(1, 40)), 2, 5);

    wait_idle();
    $display("Run covered %0d items over %0d source-count settings, with %0d records",
             sb.items_in, settings_used, sb.records_out);
    $display("merged, %0d merges completed and %0d wrong-source items flagged.",
             sb.merges_done, sb.wrong_items);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
